// ===== rtl/core/pea_pkg.sv =====
// Shared types and constants for the point extent along axis block.
// No dependencies.
`default_nettype none
package pea_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned ProdW    = 65;
  localparam int unsigned DotW     = 66;
  localparam int unsigned DenW     = 64;
  localparam int unsigned NumW     = 81;
  localparam int unsigned DivCntW  = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam logic [CoordW-1:0] DirZReset = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AXIS_PX = 3'd0,
    REG_AXIS_PY = 3'd1,
    REG_AXIS_PZ = 3'd2,
    REG_DIR_X   = 3'd3,
    REG_DIR_Y   = 3'd4,
    REG_DIR_Z   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] top_x;
    logic signed [CoordW-1:0] top_y;
    logic signed [CoordW-1:0] top_z;
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] base_z;
  } extent_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] ap;
    logic [2:0][CoordW-1:0] dir;
  } cfg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic                    last;
  } diff_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

// ===== rtl/core/pea_front.sv =====
// Front end: takes points, forms the offset from the axis point, queues it.
// Depends on pea_pkg.
`default_nettype none
module pea_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pea_pkg::cfg_t   cfg_i,
  input  wire logic            push_i,
  input  wire pea_pkg::point_t pt_i,
  output logic                 full_o,
  output pea_pkg::diff_t       diff_o,
  output logic                 diff_valid_o,
  input  wire logic            diff_pop_i
);
  import pea_pkg::*;

  diff_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  diff_t       item;
  logic        do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign diff_valid_o = (cnt_q != 2'd0);
  assign diff_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = diff_pop_i && diff_valid_o;

  always_comb begin
    item.dx   = DiffW'(pt_i.px) - DiffW'($signed(cfg_i.ap[0]));
    item.dy   = DiffW'(pt_i.py) - DiffW'($signed(cfg_i.ap[1]));
    item.dz   = DiffW'(pt_i.pz) - DiffW'($signed(cfg_i.ap[2]));
    item.last = pt_i.last_point;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree when empty");

endmodule
`default_nettype wire

// ===== rtl/core/pea_back.sv =====
// Back end: dot product, bit-serial divide, extreme tracking and projection.
// Depends on pea_pkg; one shared multiplier, restoring divider.
`default_nettype none
module pea_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pea_pkg::cfg_t    cfg_i,
  input  wire pea_pkg::diff_t   diff_i,
  input  wire pea_pkg::hs_t     diff_hs_i,
  output logic                  diff_pop_o,
  output pea_pkg::extent_t      res_o,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i
);
  import pea_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SETUP, S_DIV, S_FIN, S_CMP, S_PROJ, S_EMIT
  } state_e;

  state_e                     state_q;
  logic [2:0]                 cnt_q;
  logic [DivCntW-1:0]         div_cnt_q;
  logic signed [DiffW-1:0]    dx_q, dy_q, dz_q;
  logic                       last_q;
  logic signed [ProdW-1:0]    prod_q;
  logic signed [DotW-1:0]     dot_q;
  logic [DenW-1:0]            den_q;
  logic [NumW-1:0]            num_q;
  logic [DenW-1:0]            rem_q;
  logic [DiffW-1:0]           q_q;
  logic                       ovf_q, neg_q, side_q;
  logic signed [CoordW-1:0]   t_q, hi_t_q, lo_t_q;
  logic [2:0][CoordW-1:0]     hi_pt_q, lo_pt_q;

  logic signed [DiffW-1:0]    mul_a;
  logic signed [CoordW-1:0]   mul_b;
  logic signed [ProdW-1:0]    mul_p;
  logic [CoordW-1:0]          dsel, asel;
  logic [1:0]                 pk;
  logic [DenW:0]              rem_sh, rem_sub;
  logic [DotW-1:0]            mag;
  logic signed [49:0]         psum;
  logic [CoordW-1:0]          psat;

  assign diff_pop_o  = (state_q == S_IDLE) && diff_hs_i.valid;
  assign res_valid_o = (state_q == S_EMIT);
  assign pk          = cnt_q[1:0] - 2'd1;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    dsel = cfg_i.dir[0];
      2'd1:    dsel = cfg_i.dir[1];
      default: dsel = cfg_i.dir[2];
    endcase
    case (pk)
      2'd0:    asel = cfg_i.ap[0];
      2'd1:    asel = cfg_i.ap[1];
      default: asel = cfg_i.ap[2];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_PROJ) begin
      mul_a = DiffW'($signed(dsel));
      mul_b = t_q;
    end else begin
      case (cnt_q)
        3'd0:    begin mul_a = dx_q; mul_b = $signed(cfg_i.dir[0]); end
        3'd1:    begin mul_a = dy_q; mul_b = $signed(cfg_i.dir[1]); end
        3'd2:    begin mul_a = dz_q; mul_b = $signed(cfg_i.dir[2]); end
        3'd3:    begin mul_a = DiffW'($signed(cfg_i.dir[0])); mul_b = $signed(cfg_i.dir[0]); end
        3'd4:    begin mul_a = DiffW'($signed(cfg_i.dir[1])); mul_b = $signed(cfg_i.dir[1]); end
        3'd5:    begin mul_a = DiffW'($signed(cfg_i.dir[2])); mul_b = $signed(cfg_i.dir[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
    mul_p   = ProdW'(mul_a * ProdW'(mul_b));
    rem_sh  = {rem_q, num_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    mag     = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
    psum    = 50'($signed(asel)) + 50'($signed(prod_q[ProdW-1:16]));
    if (psum > 50'sh7FFF_FFFF)        psat = 32'h7FFF_FFFF;
    else if (psum < -50'sh8000_0000)  psat = 32'h8000_0000;
    else                              psat = psum[CoordW-1:0];
  end

  always_comb begin
    res_o.top_x  = (hi_t_q > 0) ? hi_pt_q[0] : cfg_i.ap[0];
    res_o.top_y  = (hi_t_q > 0) ? hi_pt_q[1] : cfg_i.ap[1];
    res_o.top_z  = (hi_t_q > 0) ? hi_pt_q[2] : cfg_i.ap[2];
    res_o.base_x = (lo_t_q < 0) ? lo_pt_q[0] : cfg_i.ap[0];
    res_o.base_y = (lo_t_q < 0) ? lo_pt_q[1] : cfg_i.ap[1];
    res_o.base_z = (lo_t_q < 0) ? lo_pt_q[2] : cfg_i.ap[2];
  end

  always_ff @(posedge clk_i) begin
    if (diff_pop_o) begin
      dx_q   <= diff_i.dx;
      dy_q   <= diff_i.dy;
      dz_q   <= diff_i.dz;
      last_q <= diff_i.last;
    end
    if ((state_q == S_MUL || state_q == S_PROJ) && cnt_q < 3'd6) prod_q <= mul_p;
    if (state_q == S_PROJ && cnt_q != 3'd0) begin
      if (side_q) hi_pt_q[pk] <= psat;
      else        lo_pt_q[pk] <= psat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      div_cnt_q <= '0;
      dot_q     <= '0;
      den_q     <= '0;
      num_q     <= '0;
      rem_q     <= '0;
      q_q       <= '0;
      ovf_q     <= 1'b0;
      neg_q     <= 1'b0;
      side_q    <= 1'b0;
      t_q       <= '0;
      hi_t_q    <= '0;
      lo_t_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (diff_hs_i.valid) begin
            cnt_q   <= '0;
            dot_q   <= '0;
            den_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_q >= 3'd1 && cnt_q <= 3'd3) dot_q <= dot_q + DotW'(prod_q);
          if (cnt_q >= 3'd4) den_q <= den_q + prod_q[DenW-1:0];
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd6) state_q <= S_SETUP;
        end
        S_SETUP: begin
          if (den_q == '0) begin
            t_q     <= '0;
            state_q <= S_CMP;
          end else begin
            neg_q     <= dot_q[DotW-1];
            num_q     <= {mag[NumW-17:0], 16'h0000};
            rem_q     <= '0;
            q_q       <= '0;
            ovf_q     <= 1'b0;
            div_cnt_q <= DivCntW'(NumW - 1);
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          num_q <= {num_q[NumW-2:0], 1'b0};
          ovf_q <= ovf_q | q_q[DiffW-1];
          if (!rem_sub[DenW]) begin
            rem_q <= rem_sub[DenW-1:0];
            q_q   <= {q_q[DiffW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[DenW-1:0];
            q_q   <= {q_q[DiffW-2:0], 1'b0};
          end
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) state_q <= S_FIN;
        end
        S_FIN: begin
          if (neg_q) begin
            t_q <= (ovf_q || q_q >= 33'h0_8000_0000) ? 32'sh8000_0000
                                                      : -$signed(q_q[CoordW-1:0]);
          end else begin
            t_q <= (ovf_q || q_q[DiffW-1:DiffW-2] != 2'b00) ? 32'sh7FFF_FFFF
                                                             : $signed(q_q[CoordW-1:0]);
          end
          state_q <= S_CMP;
        end
        S_CMP: begin
          cnt_q <= '0;
          if (t_q > hi_t_q) begin
            hi_t_q  <= t_q;
            side_q  <= 1'b1;
            state_q <= S_PROJ;
          end else if (t_q < lo_t_q) begin
            lo_t_q  <= t_q;
            side_q  <= 1'b0;
            state_q <= S_PROJ;
          end else begin
            state_q <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_PROJ: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd3) state_q <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (res_ready_i) begin
            hi_t_q  <= '0;
            lo_t_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !hi_t_q[CoordW-1] && !(lo_t_q > 0))
    else $error("running extremes on wrong side of zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> (hi_t_q == 0 && lo_t_q == 0))
    else $error("extremes not cleared after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROJ) |-> (cnt_q <= 3'd3))
    else $error("projection step out of range");

endmodule
`default_nettype wire

// ===== rtl/core/point_extent_along_axis.sv =====
// The back end works on one point at a time; the 81-step divider sets the pace, with a
// two-point queue ahead of it. A zero direction skips the divide, a point that moves an
// extreme adds the projection steps, and the result for a last point goes to the one-entry
// output register; while that register is held, the back end stalls on the result.
// Reset is asynchronous, active low; it restores axis point 0,0,0, direction 0,0,1.0
// and clears the running extremes. Depends on pea_pkg, pea_front, pea_back.
`default_nettype none
module point_extent_along_axis (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_idx_i,
  input  wire logic [31:0]              cfg_wdata_i,
  input  wire logic                     push,
  input  wire pea_pkg::point_t          in_i,
  output logic                          full,
  input  wire logic                     pop,
  output logic                          empty,
  output pea_pkg::extent_t              out_o
);
  import pea_pkg::*;

  cfg_t    cfg_q;
  diff_t   diff;
  hs_t     diff_hs;
  logic    diff_pop;
  extent_t res;
  logic    res_valid, res_ready;
  extent_t out_q;
  logic    out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ap  <= '0;
      cfg_q.dir <= {DirZReset, 32'h0, 32'h0};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_AXIS_PX: cfg_q.ap[0]  <= cfg_wdata_i;
        REG_AXIS_PY: cfg_q.ap[1]  <= cfg_wdata_i;
        REG_AXIS_PZ: cfg_q.ap[2]  <= cfg_wdata_i;
        REG_DIR_X:   cfg_q.dir[0] <= cfg_wdata_i;
        REG_DIR_Y:   cfg_q.dir[1] <= cfg_wdata_i;
        REG_DIR_Z:   cfg_q.dir[2] <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  pea_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .pt_i         (in_i),
    .full_o       (full),
    .diff_o       (diff),
    .diff_valid_o (diff_hs.valid),
    .diff_pop_i   (diff_pop)
  );

  assign diff_hs.ready = diff_pop;

  pea_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .diff_i      (diff),
    .diff_hs_i   (diff_hs),
    .diff_pop_o  (diff_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || pop;
  assign empty     = !out_valid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

endmodule
`default_nettype wire

// ===== tb/point_extent_along_axis_tb.sv =====
// Self-checking testbench for point_extent_along_axis: directed table, then random clouds
// under several axis settings, checked against an in-bench predictor of the extent logic.
// Depends on pea_pkg and the point_extent_along_axis RTL.
`default_nettype none
module point_extent_along_axis_tb;
  import pea_pkg::*;

  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;
  localparam int unsigned DrainCycles = 400;

  typedef struct {
    point_t  pt;
    bit      known;
    extent_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  point_t      in_i = '0;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  extent_t     out_o;

  point_extent_along_axis u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .in_i, .full, .pop, .empty, .out_o
  );

  always #2 clk_i = ~clk_i;

  logic signed [31:0] axis_pt [3];
  logic signed [31:0] dir_v [3];
  logic signed [31:0] top_t, base_t;
  logic signed [31:0] top_pt [3];
  logic signed [31:0] base_pt [3];
  extent_t extent_q [$];
  int errors = 0;
  int n_points = 0;
  int n_extents = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic signed [31:0] axis_param(logic signed [33:0] dx,
      logic signed [33:0] dy, logic signed [33:0] dz);
    logic signed [68:0] dot;
    logic [127:0] den, num, q;
    logic neg;
    den = 128'(64'(dir_v[0]) * 64'(dir_v[0]))
        + 128'(64'(dir_v[1]) * 64'(dir_v[1]))
        + 128'(64'(dir_v[2]) * 64'(dir_v[2]));
    if (den == 0) return 0;
    dot = 69'(dx) * 69'(dir_v[0]) + 69'(dy) * 69'(dir_v[1]) + 69'(dz) * 69'(dir_v[2]);
    neg = dot[68];
    num = 128'(neg ? -dot : dot) << 16;
    q = num / den;
    if (neg) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(32'(q));
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  function automatic logic signed [31:0] project(logic signed [31:0] a,
      logic signed [31:0] d, logic signed [31:0] t);
    logic signed [63:0] prod;
    logic signed [65:0] sum;
    prod = 64'(d) * 64'(t);
    sum = 66'(a) + 66'(prod >>> 16);
    if (sum > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (sum < -66'sd2147483648) return 32'sh8000_0000;
    return 32'(sum);
  endfunction

  function automatic void clear_extent();
    top_t = 0;
    base_t = 0;
    for (int k = 0; k < 3; k++) begin
      top_pt[k] = axis_pt[k];
      base_pt[k] = axis_pt[k];
    end
  endfunction

  function automatic bit fold_point(point_t p, output extent_t r);
    logic signed [31:0] t;
    t = axis_param(34'(p.px) - 34'(axis_pt[0]), 34'(p.py) - 34'(axis_pt[1]),
                   34'(p.pz) - 34'(axis_pt[2]));
    if (t > top_t) begin
      top_t = t;
      for (int k = 0; k < 3; k++) top_pt[k] = project(axis_pt[k], dir_v[k], t);
    end
    if (t < base_t) begin
      base_t = t;
      for (int k = 0; k < 3; k++) base_pt[k] = project(axis_pt[k], dir_v[k], t);
    end
    r = '0;
    if (!p.last_point) return 0;
    r.top_x  = (top_t > 0) ? top_pt[0] : axis_pt[0];
    r.top_y  = (top_t > 0) ? top_pt[1] : axis_pt[1];
    r.top_z  = (top_t > 0) ? top_pt[2] : axis_pt[2];
    r.base_x = (base_t < 0) ? base_pt[0] : axis_pt[0];
    r.base_y = (base_t < 0) ? base_pt[1] : axis_pt[1];
    r.base_z = (base_t < 0) ? base_pt[2] : axis_pt[2];
    clear_extent();
    return 1;
  endfunction

  task automatic send_point(point_t p, bit known, extent_t want);
    extent_t r;
    push = 1'b1;
    in_i = p;
    do @(posedge clk_i); while (full);
    n_points++;
    if (fold_point(p, r)) extent_q.push_back(known ? want : r);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    if (idx <= REG_AXIS_PZ) axis_pt[idx] = val;
    else if (idx <= REG_DIR_Z) dir_v[idx - REG_DIR_X] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    wait (extent_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(logic signed [31:0] base);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return base + $signed(32'($urandom_range(0, 32'h000A_0000))) - 32'sh0005_0000;
    endcase
  endfunction

  function automatic point_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit l);
    point_t p;
    p.px = x;
    p.py = y;
    p.pz = z;
    p.last_point = l;
    return p;
  endfunction

  int pop_mode = 0;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) pop_mode <= $urandom_range(0, 2);
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= $urandom_range(0, 1);
      default: pop <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (extent_q.size() == 0) begin
        report("unexpected item", out_o.top_x, '0);
      end else begin
        extent_t w;
        w = extent_q.pop_front();
        n_extents++;
        if (out_o.top_x != w.top_x) report("top_x", out_o.top_x, w.top_x);
        if (out_o.top_y != w.top_y) report("top_y", out_o.top_y, w.top_y);
        if (out_o.top_z != w.top_z) report("top_z", out_o.top_z, w.top_z);
        if (out_o.base_x != w.base_x) report("base_x", out_o.base_x, w.base_x);
        if (out_o.base_y != w.base_y) report("base_y", out_o.base_y, w.base_y);
        if (out_o.base_z != w.base_z) report("base_z", out_o.base_z, w.base_z);
      end
    end
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t rw;
    extent_t z;
    point_t p;
    int left, len, gap;
    axis_pt = '{0, 0, 0};
    dir_v = '{0, 0, 32'(DirZReset)};
    clear_extent();
    z = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    rw.known = 1; rw.res = z;
    rw.pt = mk(0, 0, 32'h0005_0000, 1); rw.res.top_z = 32'h0005_0000; rows.push_back(rw);
    rw.res = z; rw.pt = mk(0, 0, 32'hFFFD_0000, 1); rw.res.base_z = 32'hFFFD_0000;
    rows.push_back(rw);
    rw.res = z; rw.pt = mk(0, 0, 32'h7FFF_FFFF, 1); rw.res.top_z = 32'h7FFF_FFFF;
    rows.push_back(rw);
    rw.res = z; rw.pt = mk(0, 0, 32'h8000_0000, 1); rw.res.base_z = 32'h8000_0000;
    rows.push_back(rw);
    rw.res = z; rw.pt = mk(0, 0, 0, 1); rows.push_back(rw);
    rw.known = 0;
    rw.pt = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0); rows.push_back(rw);
    rw.known = 1; rw.res = z; rw.res.top_z = 32'h0001_0000;
    rw.pt = mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1); rows.push_back(rw);
    rw.known = 0;
    rw.pt = mk(32'h0001_0000, 32'h0002_0000, 32'h0007_0000, 0); rows.push_back(rw);
    rw.pt = mk(32'hFFFF_0000, 32'h0003_8000, 32'hFFFE_0000, 0); rows.push_back(rw);
    rw.pt = mk(32'h0000_0001, 32'hFFFF_FFFF, 32'h0009_0000, 0); rows.push_back(rw);
    rw.pt = mk(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 1); rows.push_back(rw);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_DIR_X, 32'h0001_0000);
          write_reg(REG_DIR_Z, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_AXIS_PX, 32'h7FFF_FFFF);
          write_reg(REG_AXIS_PY, 32'h8000_0000);
          write_reg(REG_AXIS_PZ, 32'h7FFF_FFFF);
          write_reg(REG_DIR_X, 32'h7FFF_FFFF);
          write_reg(REG_DIR_Y, 32'h8000_0000);
          write_reg(REG_DIR_Z, 32'h0000_0001);
        end
        2: begin
          write_reg(REG_DIR_X, 0);
          write_reg(REG_DIR_Y, 0);
          write_reg(REG_DIR_Z, 0);
          write_reg(REG_AXIS_PX, $urandom());
          write_reg(RegNone, $urandom());
        end
        default: begin
          write_reg(REG_AXIS_PX, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h000F_FFFF));
          write_reg(REG_AXIS_PY, $urandom_range(0, 32'h000F_FFFF));
          write_reg(REG_AXIS_PZ, $urandom());
          write_reg(REG_DIR_X, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0002_0000));
          write_reg(REG_DIR_Y, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
          write_reg(REG_DIR_Z, $urandom());
        end
      endcase
      clear_extent();
      left = 75;
      while (left > 0) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          p = mk(rand_coord(axis_pt[0]), rand_coord(axis_pt[1]), rand_coord(axis_pt[2]),
                 (k == len - 1) && ($urandom_range(0, 7) != 0));
          send_point(p, 0, z);
          left--;
          if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 20);
            repeat (gap) @(negedge clk_i);
          end
        end
      end
      p = mk($urandom(), $urandom(), $urandom(), 1);
      send_point(p, 0, z);
    end

    wait (extent_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d points, %0d extents over 9 axis settings", n_points, n_extents);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/pea_pkg.sv
rtl/core/pea_front.sv
rtl/core/pea_back.sv
rtl/core/point_extent_along_axis.sv
tb/point_extent_along_axis_tb.sv
